/* sv/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types, sizes and helpers for the LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int DICT_ENTRIES      = 4096;
	localparam int MAX_STRING_LENGTH = 64;
	localparam int BASE_ENTRIES      = 27;

	localparam int CODE_W  = 12;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = $clog2(DICT_ENTRIES);
	localparam int COUNT_W = $clog2(DICT_ENTRIES + 1);
	localparam int LEN_W   = $clog2(MAX_STRING_LENGTH + 1);
	localparam int BUF_W   = $clog2(MAX_STRING_LENGTH);
	localparam int CMP_W   = (COUNT_W > CODE_W) ? COUNT_W : CODE_W + 1;

	localparam logic [CHAR_W-1:0] HASH_CHAR   = 8'h23;
	localparam logic [CHAR_W-1:0] LETTER_A    = 8'h41;
	localparam logic [CHAR_W-1:0] NULL_CHAR   = 8'h00;

	typedef struct packed {
		logic [CODE_W-1:0] code_word;
		logic              new_message;
	} lzw_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last;
		logic              error;
	} lzw_result_t;

	typedef struct packed {
		logic [IDX_W-1:0]  prefix;
		logic [CHAR_W-1:0] tail;
		logic [CHAR_W-1:0] head;
		logic [LEN_W-1:0]  len;
	} dict_entry_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic look;
		logic walk;
		logic emit;
		logic err;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic invalid;
		logic single;
		logic walk_done;
		logic emit_done;
		logic out_free;
	} dp_status_t;

	// fixed base entries: '#' then 'A'..'Z'
	function automatic dict_entry_t base_entry(input logic [IDX_W-1:0] idx);
		dict_entry_t e;
		logic [CHAR_W-1:0] ch;
		if (idx == '0) begin
			ch = HASH_CHAR;
		end else begin
			ch = LETTER_A + CHAR_W'(idx) - CHAR_W'(1);
		end
		e.prefix = '0;
		e.tail   = ch;
		e.head   = ch;
		e.len    = LEN_W'(1);
		return e;
	endfunction

endpackage

/* sv/lzwd_ram.sv */
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/lzwd_datapath.sv */
// ----------------------------------------------------------------------------
// lzwd_datapath
// Dictionary, prefix chain walk, reverse buffer and output register.
// ----------------------------------------------------------------------------
module lzwd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzwd_pkg::ctrl_cmd_t  cmd,
	output lzwd_pkg::dp_status_t sts,
	input  lzwd_pkg::lzw_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lzwd_pkg::lzw_result_t result
);

	import lzwd_pkg::*;

	// state
	logic [CODE_W-1:0]  code_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [IDX_W-1:0]   prev_idx_q;
	logic [LEN_W-1:0]   prev_len_q;
	logic [CHAR_W-1:0]  prev_head_q;
	logic               have_prev_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   walk_idx_q;
	logic [BUF_W-1:0]   k_q;
	logic [LEN_W-1:0]   rd_cnt_q;
	logic [LEN_W-1:0]   ld_cnt_q;
	logic               pend_q;
	logic               out_valid_q;
	lzw_result_t        out_q;

	// dictionary ram
	logic               dict_we;
	logic [IDX_W-1:0]   dict_waddr;
	dict_entry_t        dict_wdata;
	logic               dict_re;
	logic [IDX_W-1:0]   dict_raddr;
	dict_entry_t        dict_rd;

	// reverse buffer ram
	logic               buf_we;
	logic [BUF_W-1:0]   buf_waddr;
	logic [CHAR_W-1:0]  buf_wdata;
	logic               buf_re;
	logic [BUF_W-1:0]   buf_raddr;
	logic [CHAR_W-1:0]  buf_rdata;

	// decode
	logic [CMP_W-1:0]   code_cmp;
	logic [CMP_W-1:0]   count_cmp;
	logic               known;
	logic               kwkwk;
	logic               invalid;
	logic [LEN_W:0]     prev_len_inc;
	logic               can_add;
	logic               look_ok;
	dict_entry_t        code_e;
	dict_entry_t        new_e;
	dict_entry_t        sel_e;
	dict_entry_t        walk_e;

	// emit
	logic               out_free;
	logic               load;
	logic               issue;
	logic               last_char;
	logic               err_load;

	assign code_cmp     = CMP_W'(code_q);
	assign count_cmp    = CMP_W'(entry_count_q);
	assign known        = code_cmp < count_cmp;
	assign prev_len_inc = (LEN_W+1)'(prev_len_q) + (LEN_W+1)'(1);
	assign can_add      = have_prev_q && (entry_count_q < COUNT_W'(DICT_ENTRIES)) &&
		(prev_len_inc <= (LEN_W+1)'(MAX_STRING_LENGTH));
	// code equal to the next free index: previous string plus its own head
	assign kwkwk        = !known && (code_cmp == count_cmp) && can_add;
	assign invalid      = !known && !kwkwk;
	assign look_ok      = cmd.look && !invalid;

	assign code_e = (code_q < CODE_W'(BASE_ENTRIES)) ? base_entry(IDX_W'(code_q)) : dict_rd;

	always_comb begin
		new_e.prefix = prev_idx_q;
		new_e.head   = prev_head_q;
		new_e.tail   = known ? code_e.head : prev_head_q;
		new_e.len    = prev_len_inc[LEN_W-1:0];
	end

	assign sel_e  = known ? code_e : new_e;
	assign walk_e = (walk_idx_q < IDX_W'(BASE_ENTRIES)) ? base_entry(walk_idx_q) : dict_rd;

	assign dict_we    = look_ok && can_add;
	assign dict_waddr = entry_count_q[IDX_W-1:0];
	assign dict_wdata = new_e;

	always_comb begin
		dict_re    = 1'b0;
		dict_raddr = IDX_W'(item.code_word);
		if (cmd.accept) begin
			dict_re    = 1'b1;
			dict_raddr = IDX_W'(item.code_word);
		end else if (look_ok && sel_e.len != LEN_W'(1)) begin
			dict_re    = 1'b1;
			dict_raddr = sel_e.prefix;
		end else if (cmd.walk && k_q != '0) begin
			dict_re    = 1'b1;
			dict_raddr = walk_e.prefix;
		end
	end

	// chain is walked tail first, so characters land in the buffer back to front
	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = k_q;
		buf_wdata = walk_e.tail;
		if (look_ok) begin
			buf_we    = 1'b1;
			buf_waddr = BUF_W'(sel_e.len - LEN_W'(1));
			buf_wdata = sel_e.tail;
		end else if (cmd.walk) begin
			buf_we    = 1'b1;
			buf_waddr = k_q;
			buf_wdata = walk_e.tail;
		end
	end

	assign out_free  = !out_valid_q || result_ready;
	assign load      = cmd.emit && pend_q && out_free;
	assign issue     = cmd.emit && (rd_cnt_q < len_q) && (!pend_q || load);
	assign last_char = ld_cnt_q == (len_q - LEN_W'(1));
	assign err_load  = cmd.err && out_free;
	assign buf_re    = issue;
	assign buf_raddr = BUF_W'(rd_cnt_q);

	lzwd_ram #(
		.WIDTH($bits(dict_entry_t)),
		.DEPTH(DICT_ENTRIES)
	) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (dict_wdata),
		.re    (dict_re),
		.raddr (dict_raddr),
		.rdata (dict_rd)
	);

	lzwd_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_STRING_LENGTH)
	) u_rev (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= COUNT_W'(BASE_ENTRIES);
			prev_idx_q    <= '0;
			have_prev_q   <= 1'b0;
			rd_cnt_q      <= '0;
			ld_cnt_q      <= '0;
			pend_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.accept && item.new_message) begin
				entry_count_q <= COUNT_W'(BASE_ENTRIES);
				prev_idx_q    <= '0;
				have_prev_q   <= 1'b0;
			end
			if (look_ok) begin
				if (can_add) begin
					entry_count_q <= entry_count_q + COUNT_W'(1);
				end
				prev_idx_q  <= IDX_W'(code_q);
				have_prev_q <= 1'b1;
				rd_cnt_q    <= '0;
				ld_cnt_q    <= '0;
				pend_q      <= 1'b0;
			end
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + LEN_W'(1);
				pend_q   <= 1'b1;
			end else if (load) begin
				pend_q   <= 1'b0;
			end
			if (load) begin
				ld_cnt_q <= ld_cnt_q + LEN_W'(1);
			end
			if (load || err_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= item.code_word;
		end
		if (look_ok) begin
			prev_len_q  <= sel_e.len;
			prev_head_q <= sel_e.head;
			len_q       <= sel_e.len;
			walk_idx_q  <= sel_e.prefix;
			k_q         <= BUF_W'(sel_e.len - LEN_W'(2));
		end
		if (cmd.walk) begin
			walk_idx_q <= walk_e.prefix;
			k_q        <= k_q - BUF_W'(1);
		end
		if (load) begin
			out_q.out_char <= buf_rdata;
			out_q.last     <= last_char;
			out_q.error    <= 1'b0;
		end else if (err_load) begin
			out_q.out_char <= NULL_CHAR;
			out_q.last     <= 1'b1;
			out_q.error    <= 1'b1;
		end
	end

	always_comb begin
		sts.invalid   = invalid;
		sts.single    = sel_e.len == LEN_W'(1);
		sts.walk_done = k_q == '0;
		sts.emit_done = load && last_char;
		sts.out_free  = out_free;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_count_q >= COUNT_W'(BASE_ENTRIES)) &&
		(entry_count_q <= COUNT_W'(DICT_ENTRIES)))
		else $error("entry count out of range");

	a_emit_balance: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q == ld_cnt_q + LEN_W'(pend_q))
		else $error("buffer reads and output loads out of step");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> rd_cnt_q <= len_q)
		else $error("buffer read past string length");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		err_load |=> (out_valid_q && out_q.error && out_q.last))
		else $error("error word not presented");

endmodule

/* sv/lzwd_ctrl.sv */
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: accept, dictionary lookup, chain walk, character output, error word.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output lzwd_pkg::ctrl_cmd_t  cmd,
	input  lzwd_pkg::dp_status_t sts
);

	import lzwd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOOK = 5'b00010,
		ST_WALK = 5'b00100,
		ST_EMIT = 5'b01000,
		ST_ERR  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (sts.invalid) begin
					state_d = ST_ERR;
				end else if (sts.single) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// last word sits in the output register, next code may come in
				if (sts.emit_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = state_q == ST_IDLE;

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && item_valid;
		cmd.look   = state_q == ST_LOOK;
		cmd.walk   = state_q == ST_WALK;
		cmd.emit   = state_q == ST_EMIT;
		cmd.err    = state_q == ST_ERR;
	end

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.emit_done) |=> item_ready)
		else $error("not ready after final character");

endmodule

/* sv/lzw_decoder_top.sv */
// ----------------------------------------------------------------------------
// lzw_decoder_top
// LZW decoder: one code in, its string out one character per word.
// ----------------------------------------------------------------------------
// A code is taken and looked up in the dictionary, and the prefix chain of a
// longer string is walked one entry per cycle through the read port of the
// dictionary RAM; its characters are then read out of the reverse buffer RAM
// into the output register, waiting while the output is held. An invalid
// code gives one error word. A new code is taken while the final character
// still waits in the output register. No clearing pass follows reset: the
// base entries are fixed logic and every other entry is written before it
// can be reached.
module lzw_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  lzwd_pkg::lzw_item_t   item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output lzwd_pkg::lzw_result_t result
);

	import lzwd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	lzwd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	lzwd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* tb/sv/lzw_decoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_decoder_top_test
// Self-checking bench for the LZW decoder. Codes go in over valid/ready and a
// dictionary kept in the bench predicts every decoded word. A short directed
// plan comes first. A pass then fills the dictionary to the top, followed by
// random messages, KwKwK chains up to the length limit, and noise. Both sides
// idle in random bursts.
// ----------------------------------------------------------------------------
module lzw_decoder_top_test;
	import lzwd_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              new_msg;
		logic              fixed;   // expected word written out in the plan
		logic              err;
		logic [CHAR_W-1:0] ch;
	} plan_row_t;

	localparam int PLAN_LEN = 24;
	localparam logic [CODE_W-1:0] MAX_CODE = '1;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	lzw_item_t   item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	lzw_result_t result;

	// bench copy of the dictionary
	logic [IDX_W-1:0]   link_mem [DICT_ENTRIES];
	logic [CHAR_W-1:0]  tail_mem [DICT_ENTRIES];
	logic [CHAR_W-1:0]  head_mem [DICT_ENTRIES];
	logic [LEN_W-1:0]   len_mem  [DICT_ENTRIES];
	logic [COUNT_W-1:0] dict_count;
	logic [IDX_W-1:0]   last_code;
	logic               have_last;

	lzw_result_t expected_chars[$];
	lzw_result_t cur_string[$];
	plan_row_t   plan [PLAN_LEN];

	int unsigned n_fail = 0;
	int unsigned n_sent = 0;
	int          stall_left = 0;
	logic        tx_idle = 1'b0;
	logic        rx_idle = 1'b0;

	lzw_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("lzw_decoder_top test failed");
		$finish;
	end

	function automatic void restart_dict();
		for (int i = 0; i < BASE_ENTRIES; i++) begin
			head_mem[i] = (i == 0) ? HASH_CHAR : LETTER_A + CHAR_W'(i - 1);
			tail_mem[i] = head_mem[i];
			link_mem[i] = '0;
			len_mem[i]  = LEN_W'(1);
		end
		dict_count = COUNT_W'(BASE_ENTRIES);
		have_last  = 1'b0;
		last_code  = '0;
	endfunction

	// decodes one code into cur_string and updates the dictionary
	function automatic void decode_code(input lzw_item_t it);
		logic [CHAR_W-1:0] rev [MAX_STRING_LENGTH];
		lzw_result_t r;
		int unsigned code, n, slen, idx;
		logic known, grow;
		code = it.code_word;
		cur_string.delete();
		if (it.new_message) restart_dict();
		known = code < dict_count;
		grow = have_last && dict_count < DICT_ENTRIES &&
			len_mem[last_code] + 1 <= MAX_STRING_LENGTH;
		// only the next free index may be used beyond the dictionary
		if (!known && !(grow && code == dict_count)) begin
			r.out_char = NULL_CHAR;
			r.last     = 1'b1;
			r.error    = 1'b1;
			cur_string.push_back(r);
			return;
		end
		if (grow) begin
			n = dict_count;
			link_mem[n] = last_code;
			head_mem[n] = head_mem[last_code];
			tail_mem[n] = known ? head_mem[code] : head_mem[last_code];
			len_mem[n]  = len_mem[last_code] + LEN_W'(1);
			dict_count  = dict_count + 1'b1;
		end
		slen = len_mem[code];
		idx  = code;
		for (int k = slen; k > 0; k--) begin
			rev[k-1] = tail_mem[idx];
			idx = link_mem[idx];
		end
		for (int k = 0; k < slen; k++) begin
			r.out_char = rev[k];
			r.last     = (k + 1 == slen);
			r.error    = 1'b0;
			cur_string.push_back(r);
		end
		last_code = IDX_W'(code);
		have_last = 1'b1;
	endfunction

	function automatic logic [CODE_W-1:0] rand_letter();
		return CODE_W'($urandom_range(0, BASE_ENTRIES - 1));
	endfunction

	// kwkwk code while there is room, else the top code
	function automatic logic [CODE_W-1:0] next_free();
		return (dict_count < DICT_ENTRIES) ? CODE_W'(dict_count) : MAX_CODE;
	endfunction

	// mostly recent entries, so strings get long
	function automatic logic [CODE_W-1:0] pick_known();
		int unsigned sel, top;
		sel = $urandom_range(0, 9);
		top = dict_count - 1;
		if (sel < 5) return CODE_W'(top - $urandom_range(0, 7));
		if (sel < 8) return rand_letter();
		return CODE_W'($urandom_range(0, top));
	endfunction

	task automatic put_item(input logic [CODE_W-1:0] code, input logic nm);
		lzw_item_t it;
		it.code_word   = code;
		it.new_message = nm;
		if (tx_idle && $urandom_range(0, 2) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		n_sent++;
		decode_code(it);
	endtask

	task automatic send(input logic [CODE_W-1:0] code, input logic nm);
		put_item(code, nm);
		foreach (cur_string[i]) expected_chars.push_back(cur_string[i]);
	endtask

	// hold off the sender until every pending word is back
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_chars.size() != 0);
	endtask

	task automatic send_message(input int n);
		int unsigned sel;
		logic [CODE_W-1:0] code;
		send(rand_letter(), 1'b1);
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) code = next_free();
			else if (sel < 90) code = pick_known();
			else code = CODE_W'($urandom_range(0, 4095));
			send(code, 1'b0);
		end
	endtask

	// kwkwk codes one after another until the string hits the length limit
	task automatic grow_chain();
		logic [CODE_W-1:0] longest;
		send(rand_letter(), 1'b1);
		do send(next_free(), 1'b0); while (!cur_string[0].error);
		longest = CODE_W'(dict_count - 1);
		send(longest, 1'b0);
		send(rand_letter(), 1'b0);
		send(next_free(), 1'b0);
	endtask

	always @(posedge clk) begin
		lzw_result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_chars.size() == 0) begin
					if (n_fail < 100)
						$display("%0t: unexpected word char %h last %b error %b",
							$time, result.out_char, result.last, result.error);
					n_fail++;
				end else begin
					want = expected_chars.pop_front();
					if (result.out_char !== want.out_char || result.last !== want.last ||
						result.error !== want.error) begin
						if (n_fail < 100)
							$display("%0t: expected char %h last %b error %b, got char %h last %b error %b",
								$time, want.out_char, want.last, want.error,
								result.out_char, result.last, result.error);
						n_fail++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				result_ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				stall_left   <= $urandom_range(0, 4);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		int start;
		int unsigned pick;
		plan = '{
			'{12'd1,    1'b0, 1'b1, 1'b0, "A"},
			'{MAX_CODE, 1'b0, 1'b1, 1'b1, NULL_CHAR},
			'{12'd27,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'd26,   1'b0, 1'b1, 1'b0, "Z"},
			'{12'd28,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'd29,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'd0,    1'b0, 1'b1, 1'b0, "#"},
			'{12'd32,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'd34,   1'b0, 1'b1, 1'b1, NULL_CHAR},
			'{12'd27,   1'b1, 1'b1, 1'b1, NULL_CHAR},
			'{12'd0,    1'b1, 1'b1, 1'b0, "#"},
			'{12'd27,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'd31,   1'b0, 1'b1, 1'b1, NULL_CHAR},
			'{12'd28,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{MAX_CODE, 1'b1, 1'b1, 1'b1, NULL_CHAR},
			'{12'd26,   1'b0, 1'b1, 1'b0, "Z"},
			'{12'h800,  1'b0, 1'b1, 1'b1, NULL_CHAR},
			'{12'h7ff,  1'b0, 1'b1, 1'b1, NULL_CHAR},
			'{12'd1,    1'b0, 1'b1, 1'b0, "A"},
			'{12'd27,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'd28,   1'b0, 1'b0, 1'b0, NULL_CHAR},
			'{12'h555,  1'b1, 1'b1, 1'b1, NULL_CHAR},
			'{12'haaa,  1'b0, 1'b1, 1'b1, NULL_CHAR},
			'{12'd13,   1'b0, 1'b1, 1'b0, "M"}
		};
		for (int i = 0; i < DICT_ENTRIES; i++) begin
			link_mem[i] = '0;
			tail_mem[i] = '0;
			head_mem[i] = '0;
			len_mem[i]  = '0;
		end
		restart_dict();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		foreach (plan[i]) begin
			put_item(plan[i].code, plan[i].new_msg);
			if (plan[i].fixed)
				expected_chars.push_back('{out_char: plan[i].ch, last: 1'b1, error: plan[i].err});
			else
				foreach (cur_string[j]) expected_chars.push_back(cur_string[j]);
		end
		drain();

		// fill the dictionary to the top, mostly with single letters
		tx_idle = 1'b0;
		send(rand_letter(), 1'b1);
		while (dict_count < DICT_ENTRIES) begin
			if ($urandom_range(0, 9) == 0) send(pick_known(), 1'b0);
			else send(rand_letter(), 1'b0);
		end
		tx_idle = 1'b1;
		send(MAX_CODE, 1'b0);
		send(MAX_CODE - 1'b1, 1'b0);
		repeat (8) send(pick_known(), 1'b0);
		drain();

		grow_chain();
		start = n_sent;
		while (n_sent - start < 470) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			pick = $urandom_range(0, 19);
			if (pick < 15)
				send_message($urandom_range(3, 30));
			else if (pick < 19)
				repeat ($urandom_range(1, 4))
					send(CODE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
			else
				grow_chain();
		end

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_message(40);
		item_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (n_fail == 0) begin
			$display("lzw_decoder_top test passed");
		end else begin
			$display("lzw_decoder_top test failed");
		end
		$finish;
	end

endmodule

/* files.f */
sv/lzwd_pkg.sv
sv/lzwd_ram.sv
sv/lzwd_datapath.sv
sv/lzwd_ctrl.sv
sv/lzw_decoder_top.sv
tb/sv/lzw_decoder_top_test.sv
